### hw/rtl/tmef_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the trimmed-mean smoothing filter.
// Used by tmef_ctrl, tmef_lane and trimmed_mean_ema_filter_core; no dependencies.

package tmef_pkg;

   // Fixed field widths of the sample channels.
   localparam int VEL_W = 32;
   localparam int TRQ_W = 16;

   // Configuration port.
   localparam int CSR_INDEX_W = 4;
   localparam int KEEP_W      = 17;
   localparam logic [CSR_INDEX_W-1:0] CSR_VEL_KEEP    = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TORQUE_KEEP = 4'd1;
   localparam logic [KEEP_W-1:0] VEL_KEEP_RESET    = 17'd55706;
   localparam logic [KEEP_W-1:0] TORQUE_KEEP_RESET = 17'd52429;

   // Q16 weight arithmetic.
   localparam int Q16_BITS = 16;
   localparam logic [KEEP_W-1:0]   ONE_Q16  = 17'h10000;
   localparam logic [Q16_BITS-1:0] HALF_Q16 = 16'h8000;

   // The keep weight is consumed four bits per cycle, most significant chunk first.
   localparam int KEEP_STEP_BITS = 4;
   localparam int K_STEPS        = 5;
   localparam int KPAD_W         = K_STEPS * KEEP_STEP_BITS;
   localparam int KSEL_W         = $clog2(K_STEPS);

   // Quotient bits produced per cycle by the mean divider.
   localparam int DIV_BITS = 8;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_TRIM,
      ST_LOAD,
      ST_DIV,
      ST_MEAN,
      ST_DIFF,
      ST_MUL,
      ST_SUM,
      ST_RND,
      ST_DMAG,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic              wr_en;
      logic              scan_en;
      logic              scan_first;
      logic              trim_en;
      logic              full;
      logic              load_en;
      logic              div_en;
      logic              mean_en;
      logic              diff_en;
      logic              mul_en;
      logic              mul_first;
      logic [KSEL_W-1:0] k_sel;
      logic              sum_en;
      logic              rnd_en;
      logic              seeded;
      logic              dmag_en;
      logic              out_en;
   } lane_cmd_type;

endpackage

### hw/rtl/tmef_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the trimmed-mean smoothing filter: ring pointer, fill count,
// smoother seed flag and the step counter. Depends on tmef_pkg.

module tmef_ctrl #(
   parameter int WINDOW_LEN = 5,
   parameter int DIV_STEPS  = 7
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_restart,
   output logic                                  req_ready,
   input  logic                                  rsp_ready,
   output logic                                  rsp_valid,
   output tmef_pkg::lane_cmd_type                cmd,
   output logic [$clog2(WINDOW_LEN)-1:0]         wr_slot,
   output logic [$clog2(WINDOW_LEN)-1:0]         rd_idx,
   output logic [$clog2(WINDOW_LEN+1)-1:0]       den
);

   localparam int IDX_W     = $clog2(WINDOW_LEN);
   localparam int DEN_W     = $clog2(WINDOW_LEN + 1);
   localparam int CNT_MAX_A = (WINDOW_LEN > DIV_STEPS) ? WINDOW_LEN : DIV_STEPS;
   localparam int CNT_MAX   = (CNT_MAX_A > tmef_pkg::K_STEPS) ? CNT_MAX_A : tmef_pkg::K_STEPS;
   localparam int CNT_W     = $clog2(CNT_MAX);
   localparam logic [DEN_W-1:0] FILL_FULL = DEN_W'(WINDOW_LEN);

   tmef_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [IDX_W-1:0] slot_ff, slot_in;
   logic [DEN_W-1:0] fill_ff, fill_in;
   logic             seeded_ff, seeded_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             full;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tmef_pkg::ST_IDLE;
         cnt_ff       <= '0;
         slot_ff      <= '0;
         fill_ff      <= '0;
         seeded_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         slot_ff      <= slot_in;
         fill_ff      <= fill_in;
         seeded_ff    <= seeded_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign full      = (fill_ff == FILL_FULL);
   assign den       = full ? DEN_W'(WINDOW_LEN - 2) : fill_ff;
   assign rd_idx    = cnt_ff[IDX_W-1:0];
   assign wr_slot   = req_restart ? '0 : slot_ff;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      slot_in      = slot_ff;
      fill_in      = fill_ff;
      seeded_in    = seeded_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.full     = full;
      cmd.seeded   = seeded_ff;
      unique case (state_ff)
         tmef_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.wr_en = 1'b1;
               slot_in   = (wr_slot == IDX_W'(WINDOW_LEN - 1)) ? '0 : wr_slot + 1'b1;
               if (req_restart) begin
                  fill_in = DEN_W'(1);
               end else if (fill_ff != FILL_FULL) begin
                  fill_in = fill_ff + 1'b1;
               end
               seeded_in = seeded_ff & ~req_restart;
               cnt_in    = '0;
               state_in  = tmef_pkg::ST_SCAN;
            end
         end
         tmef_pkg::ST_SCAN: begin
            cmd.scan_en    = 1'b1;
            cmd.scan_first = (cnt_ff == '0);
            if (cnt_ff == CNT_W'(fill_ff - 1'b1)) begin
               cnt_in   = '0;
               state_in = tmef_pkg::ST_TRIM;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         tmef_pkg::ST_TRIM: begin
            cmd.trim_en = 1'b1;
            state_in    = tmef_pkg::ST_LOAD;
         end
         tmef_pkg::ST_LOAD: begin
            cmd.load_en = 1'b1;
            cnt_in      = '0;
            state_in    = tmef_pkg::ST_DIV;
         end
         tmef_pkg::ST_DIV: begin
            cmd.div_en = 1'b1;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = tmef_pkg::ST_MEAN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         tmef_pkg::ST_MEAN: begin
            cmd.mean_en = 1'b1;
            state_in    = seeded_ff ? tmef_pkg::ST_DIFF : tmef_pkg::ST_RND;
         end
         tmef_pkg::ST_DIFF: begin
            cmd.diff_en = 1'b1;
            cnt_in      = '0;
            state_in    = tmef_pkg::ST_MUL;
         end
         tmef_pkg::ST_MUL: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_first = (cnt_ff == '0);
            cmd.k_sel     = tmef_pkg::KSEL_W'(tmef_pkg::K_STEPS - 1)
                            - cnt_ff[tmef_pkg::KSEL_W-1:0];
            if (cnt_ff == CNT_W'(tmef_pkg::K_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = tmef_pkg::ST_SUM;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         tmef_pkg::ST_SUM: begin
            cmd.sum_en = 1'b1;
            state_in   = tmef_pkg::ST_RND;
         end
         tmef_pkg::ST_RND: begin
            cmd.rnd_en = 1'b1;
            seeded_in  = 1'b1;
            state_in   = tmef_pkg::ST_DMAG;
         end
         tmef_pkg::ST_DMAG: begin
            cmd.dmag_en = 1'b1;
            state_in    = tmef_pkg::ST_EMIT;
         end
         tmef_pkg::ST_EMIT: begin
            // Wait here until the output register is free or being drained.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_en   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = tmef_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tmef_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

### hw/rtl/tmef_lane.sv
`timescale 1ns / 1ps
// Datapath of one filter channel: sample ring, trimmed sum, mean divider,
// keep-weight blend and display rounding. Depends on tmef_pkg.

module tmef_lane #(
   parameter int SAMPLE_W   = 32,
   parameter int FRAC_BITS  = 16,
   parameter int WINDOW_LEN = 5,
   parameter int DIV_STEPS  = 7
) (
   input  logic                                 clock,
   input  tmef_pkg::lane_cmd_type               cmd,
   input  logic [$clog2(WINDOW_LEN)-1:0]        wr_slot,
   input  logic [$clog2(WINDOW_LEN)-1:0]        rd_idx,
   input  logic [$clog2(WINDOW_LEN+1)-1:0]      den,
   input  logic [tmef_pkg::KEEP_W-1:0]          keep,
   input  logic signed [SAMPLE_W-1:0]           sample,
   output logic signed [SAMPLE_W-1:0]           result
);

   localparam int DEN_W  = $clog2(WINDOW_LEN + 1);
   localparam int SUM_W  = SAMPLE_W + 4;
   localparam int DIV_W  = DIV_STEPS * tmef_pkg::DIV_BITS;
   localparam int SMW    = SAMPLE_W + FRAC_BITS + 1;
   localparam int DIFF_W = SMW + 1;
   localparam int KB     = tmef_pkg::KEEP_STEP_BITS;
   localparam int PROD_W = DIFF_W + KB + 1;
   localparam int ACC_W  = DIFF_W + tmef_pkg::KEEP_W;
   localparam int QB     = tmef_pkg::Q16_BITS;
   localparam logic [SAMPLE_W:0] POS_LIM = {2'b00, {(SAMPLE_W-1){1'b1}}};
   localparam logic [SAMPLE_W:0] NEG_LIM = {2'b01, {(SAMPLE_W-1){1'b0}}};

   logic signed [SAMPLE_W-1:0] ring_ff [WINDOW_LEN];
   logic signed [SAMPLE_W-1:0] entry;
   logic signed [SUM_W-1:0]    sum_ff, sum_in, tsum_ff, tsum_in;
   logic signed [SAMPLE_W-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic                       neg_ff;
   logic [SUM_W-1:0]           tmag;
   logic [DIV_W-1:0]           div_ff, div_in;
   logic [DEN_W-1:0]           rem_ff, rem_in;
   logic signed [SMW-1:0]      mean_ff, mean_in;
   logic signed [DIFF_W-1:0]   diff_ff;
   logic [tmef_pkg::KEEP_W-1:0] kclamp;
   logic [tmef_pkg::KPAD_W-1:0] kpad;
   logic [KB-1:0]              chunk;
   logic signed [PROD_W-1:0]   prod;
   logic signed [ACC_W-1:0]    acc_ff, acc_in, total_ff;
   logic signed [SMW-1:0]      qfloor;
   logic [QB-1:0]              qrem;
   logic                       bump;
   logic signed [SMW-1:0]      smooth_ff, smooth_in;
   logic                       dneg_ff;
   logic [SMW-1:0]             dmag_ff, smag;
   logic [SAMPLE_W:0]          whole;
   logic signed [SAMPLE_W-1:0] out_ff, out_in;

   // Sample ring; entries beyond the fill count are never read.
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         ring_ff[wr_slot] <= sample;
      end
   end

   // Running sum, minimum and maximum, one ring entry per cycle.
   assign entry = ring_ff[rd_idx];

   always_comb begin
      if (cmd.scan_first) begin
         sum_in = SUM_W'(entry);
         lo_in  = entry;
         hi_in  = entry;
      end else begin
         sum_in = sum_ff + SUM_W'(entry);
         lo_in  = (entry < lo_ff) ? entry : lo_ff;
         hi_in  = (entry > hi_ff) ? entry : hi_ff;
      end
   end

   assign tsum_in = cmd.full ? (sum_ff - SUM_W'(lo_ff) - SUM_W'(hi_ff)) : sum_ff;
   assign tmag    = tsum_ff[SUM_W-1] ? $unsigned(-tsum_ff) : $unsigned(tsum_ff);

   // Restoring divider on the magnitude, DIV_BITS quotient bits per cycle.
   // Quotient bits shift into the low end as the dividend leaves the top.
   always_comb begin
      logic [DIV_W-1:0] d;
      logic [DEN_W:0]   r;
      d = div_ff;
      r = {1'b0, rem_ff};
      for (int j = 0; j < tmef_pkg::DIV_BITS; j++) begin
         r = {r[DEN_W-1:0], d[DIV_W-1]};
         d = {d[DIV_W-2:0], 1'b0};
         if (r >= {1'b0, den}) begin
            r    = r - {1'b0, den};
            d[0] = 1'b1;
         end
      end
      if (cmd.load_en) begin
         div_in = DIV_W'({tmag, {FRAC_BITS{1'b0}}}) + DIV_W'(den >> 1);
         rem_in = '0;
      end else begin
         div_in = d;
         rem_in = r[DEN_W-1:0];
      end
   end

   assign mean_in = neg_ff ? -$signed(div_ff[SMW-1:0]) : $signed(div_ff[SMW-1:0]);

   // Blend as mean * 2^16 + keep * (old - mean), the product built chunk by chunk.
   assign kclamp = (keep > tmef_pkg::ONE_Q16) ? tmef_pkg::ONE_Q16 : keep;
   assign kpad   = tmef_pkg::KPAD_W'(kclamp);
   assign chunk  = kpad[cmd.k_sel * KB +: KB];
   assign prod   = diff_ff * $signed({1'b0, chunk});
   assign acc_in = cmd.mul_first ? ACC_W'(prod) : (acc_ff <<< KB) + ACC_W'(prod);

   // Floor of total / 2^16, then one up when the remainder rounds away from zero.
   assign qfloor = SMW'(total_ff >>> QB);
   assign qrem   = total_ff[QB-1:0];
   assign bump   = (qrem > tmef_pkg::HALF_Q16)
                   || ((qrem == tmef_pkg::HALF_Q16) && !total_ff[ACC_W-1]);
   assign smooth_in = cmd.seeded ? qfloor + $signed({{(SMW-1){1'b0}}, bump}) : mean_ff;

   assign smag  = smooth_ff[SMW-1] ? $unsigned(-smooth_ff) : $unsigned(smooth_ff);
   assign whole = (SAMPLE_W+1)'(dmag_ff >> FRAC_BITS);

   always_comb begin
      if (!dneg_ff && (whole > POS_LIM)) begin
         out_in = $signed(POS_LIM[SAMPLE_W-1:0]);
      end else if (dneg_ff && (whole > NEG_LIM)) begin
         out_in = $signed(NEG_LIM[SAMPLE_W-1:0]);
      end else if (dneg_ff) begin
         out_in = -$signed(whole[SAMPLE_W-1:0]);
      end else begin
         out_in = $signed(whole[SAMPLE_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_en) begin
         sum_ff <= sum_in;
         lo_ff  <= lo_in;
         hi_ff  <= hi_in;
      end
      if (cmd.trim_en) begin
         tsum_ff <= tsum_in;
      end
      if (cmd.load_en) begin
         neg_ff <= tsum_ff[SUM_W-1];
      end
      if (cmd.load_en || cmd.div_en) begin
         div_ff <= div_in;
         rem_ff <= rem_in;
      end
      if (cmd.mean_en) begin
         mean_ff <= mean_in;
      end
      if (cmd.diff_en) begin
         diff_ff <= DIFF_W'(smooth_ff) - DIFF_W'(mean_ff);
      end
      if (cmd.mul_en) begin
         acc_ff <= acc_in;
      end
      if (cmd.sum_en) begin
         total_ff <= acc_ff + (ACC_W'(mean_ff) <<< QB);
      end
      if (cmd.rnd_en) begin
         smooth_ff <= smooth_in;
      end
      if (cmd.dmag_en) begin
         dneg_ff <= smooth_ff[SMW-1];
         dmag_ff <= smag + (SMW'(1) << (FRAC_BITS - 1));
      end
      if (cmd.out_en) begin
         out_ff <= out_in;
      end
   end

   assign result = out_ff;

endmodule

### hw/rtl/trimmed_mean_ema_filter_core.sv
`timescale 1ns / 1ps
// Top level of the trimmed-mean exponential smoothing filter: stream ports,
// keep-weight registers, sequencer and one datapath lane per channel.
// Depends on tmef_pkg, tmef_ctrl and tmef_lane.
//
//   Channel  Direction  Handshake              Payload
//   req_     in         req_tvalid/req_tready  tdata: velocity, torque; tuser: restart
//   rsp_     out        rsp_tvalid/rsp_tready  tdata: velocity_display, torque_display
//   csr_     in         csr_valid/csr_ready    csr_index, csr_data (keep weights)
//
// One item at a time. After the input transfer the sequencer scans the n ring
// entries in use, trims and runs the mean divider (8 quotient bits a cycle, which
// sets DIV_STEPS); once the smoother is seeded the 4-bit-per-cycle keep multiplier
// runs as well. The result is registered once the output register is free or
// being drained, and the next item is then taken. A stalled result stays in
// the output register while the next item is computed. Reset is synchronous.

module trimmed_mean_ema_filter_core #(
   parameter int WINDOW_LEN = 5,
   parameter int FRAC_BITS  = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [31:0] velocity_sample, [47:32] torque_sample
   input  logic [47:0]                          req_tdata,
   // [0] restart
   input  logic                                 req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [31:0] velocity_display, [47:32] torque_display
   output logic [47:0]                          rsp_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [tmef_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [tmef_pkg::KEEP_W-1:0]          csr_data
);

   localparam int DIV_STEPS =
      (tmef_pkg::VEL_W + 4 + FRAC_BITS + tmef_pkg::DIV_BITS - 1) / tmef_pkg::DIV_BITS;
   localparam int IDX_W = $clog2(WINDOW_LEN);
   localparam int DEN_W = $clog2(WINDOW_LEN + 1);

   logic [tmef_pkg::KEEP_W-1:0] vel_keep_ff, torque_keep_ff;
   tmef_pkg::lane_cmd_type      cmd;
   logic [IDX_W-1:0]            wr_slot, rd_idx;
   logic [DEN_W-1:0]            den;
   logic signed [tmef_pkg::VEL_W-1:0] vel_result;
   logic signed [tmef_pkg::TRQ_W-1:0] trq_result;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vel_keep_ff    <= tmef_pkg::VEL_KEEP_RESET;
         torque_keep_ff <= tmef_pkg::TORQUE_KEEP_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            tmef_pkg::CSR_VEL_KEEP:    vel_keep_ff    <= csr_data;
            tmef_pkg::CSR_TORQUE_KEEP: torque_keep_ff <= csr_data;
            default: begin
               // Writes to unassigned indexes are dropped.
            end
         endcase
      end
   end

   tmef_ctrl #(
      .WINDOW_LEN (WINDOW_LEN),
      .DIV_STEPS  (DIV_STEPS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_restart (req_tuser),
      .req_ready   (req_tready),
      .rsp_ready   (rsp_tready),
      .rsp_valid   (rsp_tvalid),
      .cmd         (cmd),
      .wr_slot     (wr_slot),
      .rd_idx      (rd_idx),
      .den         (den)
   );

   tmef_lane #(
      .SAMPLE_W   (tmef_pkg::VEL_W),
      .FRAC_BITS  (FRAC_BITS),
      .WINDOW_LEN (WINDOW_LEN),
      .DIV_STEPS  (DIV_STEPS)
   ) u_vel_lane (
      .clock   (clock),
      .cmd     (cmd),
      .wr_slot (wr_slot),
      .rd_idx  (rd_idx),
      .den     (den),
      .keep    (vel_keep_ff),
      .sample  ($signed(req_tdata[31:0])),
      .result  (vel_result)
   );

   tmef_lane #(
      .SAMPLE_W   (tmef_pkg::TRQ_W),
      .FRAC_BITS  (FRAC_BITS),
      .WINDOW_LEN (WINDOW_LEN),
      .DIV_STEPS  (DIV_STEPS)
   ) u_trq_lane (
      .clock   (clock),
      .cmd     (cmd),
      .wr_slot (wr_slot),
      .rd_idx  (rd_idx),
      .den     (den),
      .keep    (torque_keep_ff),
      .sample  ($signed(req_tdata[47:32])),
      .result  (trq_result)
   );

   assign rsp_tdata = {trq_result, vel_result};

endmodule
